>>> rtl/windowed_rms_energy_core_defines.svh
// Assertion macros shared by the checker of windowed_rms_energy_core.
// No dependencies; include by bare file name.
`ifndef WINDOWED_RMS_ENERGY_CORE_DEFINES_SVH
`define WINDOWED_RMS_ENERGY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wre_pkg.sv
// Package for windowed_rms_energy_core: field widths, register reset value,
// sequencer state type. No dependencies.
`default_nettype none

package wre_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HOP_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int RMS_W    = 17;
  localparam int SQ_W     = 2 * SAMPLE_W;           // square of a magnitude
  localparam int SUM_W    = 47;                      // window sum of squares
  localparam int NUM_W    = SUM_W + 2;               // 4 * sum
  localparam int RAD_W    = 34;                      // 4 * sum / count, padded even
  localparam int SREM_W   = 19;                      // square root remainder
  localparam int STEP_W   = 6;                       // iteration counter

  localparam logic [HOP_W-1:0] HOP_RESET = 16'd1600;
  localparam logic [RMS_W-1:0] RMS_MAX   = 17'd65536;

  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(SAMPLE_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(RMS_W - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQUARE = 6'b000010,
    S_ACCUM  = 6'b000100,
    S_DIV    = 6'b001000,
    S_SQRT   = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/windowed_rms_energy_core.sv
// Windowed RMS energy of a signed PCM16 stream: bit-serial square, window
// accumulation, radix-2 divide and digit-by-digit square root. Depends on wre_pkg.
//
// Input (in_valid / in_stall): one PCM sample per transaction; in_end_of_stream
//   marks the last sample and closes a partial window.
// Result (out_valid / out_stall): one transaction per closed window with the
//   RMS (16 fraction bits, 65536 = 1.0), the sample count and the final flag.
// Config: cfg_wr_en writes cfg_wr_data into the window length (zero acts as
//   one). Write only while the block is idle.
// Flow: in_stall is high while a sample is worked on. A sample that leaves
//   its window open is squared by shift-add in S_SQUARE and added to the
//   sum in S_ACCUM. A closing sample goes on through S_DIV, S_SQRT and
//   S_HOLD, and out_valid rises as S_HOLD publishes. The next sample is
//   taken only once the block is back in S_IDLE.
// Reset: rst_n (synchronous, active low) clears sum and count, drops any
//   pending result and sets the window length to 1600.
// Stall: a result waits in the output register while out_stall is high;
//   samples keep flowing until the next window closes, which then holds in
//   the publish state until the waiting result is taken.
`default_nettype none

module windowed_rms_energy_core
  import wre_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  // configuration
  input  wire                      cfg_wr_en,
  input  wire  [HOP_W-1:0]         cfg_wr_data,
  // sample channel
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  signed [SAMPLE_W-1:0] in_sample,
  input  wire                      in_end_of_stream,
  // result channel
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [RMS_W-1:0]         out_rms_value,
  output logic [COUNT_W-1:0]       out_window_count,
  output logic                     out_final_window
);

  // control state
  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [HOP_W-1:0]     hop_r, hop_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // datapath registers
  logic [SQ_W-1:0]      mcand_r, mcand_nxt;
  logic [SAMPLE_W-1:0]  mplier_r, mplier_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic                 last_r, last_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [RAD_W-1:0]     quo_r, quo_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]   wcount_r, wcount_nxt;
  logic [SREM_W-1:0]    srem_r, srem_nxt;
  logic [RMS_W-1:0]     root_r, root_nxt;
  logic [RMS_W-1:0]     out_rms_r, out_rms_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 out_final_r, out_final_nxt;

  // combinational helpers
  logic                 in_take;
  logic                 out_free;
  logic [SAMPLE_W-1:0]  mag;
  logic [SUM_W-1:0]     sum_add;
  logic [COUNT_W-1:0]   count_inc;
  logic [HOP_W-1:0]     limit;
  logic                 close_win;
  logic [COUNT_W-1:0]   divisor;
  logic [COUNT_W:0]     div_trial;
  logic                 div_ge;
  logic [SREM_W+1:0]    sq_trial;
  logic [SREM_W+1:0]    sq_sub;
  logic                 sq_ge;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_rms_value    = out_rms_r;
  assign out_window_count = out_count_r;
  assign out_final_window = out_final_r;

  // Magnitude of the two's complement sample; -32768 maps to 32768.
  assign mag = in_sample[SAMPLE_W-1] ? (~in_sample + SAMPLE_W'(1)) : in_sample;

  // Window bookkeeping for the accumulate cycle.
  assign sum_add   = sum_r + SUM_W'(sq_r);
  assign count_inc = count_r + COUNT_W'(1);
  assign limit     = (hop_r == '0) ? HOP_W'(1) : hop_r;
  assign close_win = !(count_inc < limit) || last_r;

  // Restoring division step: bring down one dividend bit.
  assign divisor   = (wcount_r == '0) ? COUNT_W'(1) : wcount_r;
  assign div_trial = {rem_r, num_r[NUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, divisor});

  // Square root step: bring down two radicand bits, try 4*root + 1.
  assign sq_trial = {srem_r, quo_r[RAD_W-1 -: 2]};
  assign sq_sub   = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_trial >= sq_sub);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    hop_nxt       = hop_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    sq_nxt        = sq_r;
    last_nxt      = last_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    wcount_nxt    = wcount_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    out_rms_nxt   = out_rms_r;
    out_count_nxt = out_count_r;
    out_final_nxt = out_final_r;

    if (cfg_wr_en) begin
      hop_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        // Latch the sample and start the shift-add square.
        if (in_take) begin
          mcand_nxt  = SQ_W'(mag);
          mplier_nxt = mag;
          sq_nxt     = '0;
          last_nxt   = in_end_of_stream;
          step_nxt   = '0;
          state_nxt  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (mplier_r[0]) begin
          sq_nxt = sq_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == SQ_LAST) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if (close_win) begin
          // Hand 4*sum to the divider and open a fresh window.
          num_nxt    = {sum_add, 2'b00};
          quo_nxt    = '0;
          rem_nxt    = '0;
          wcount_nxt = count_inc;
          sum_nxt    = '0;
          count_nxt  = '0;
          step_nxt   = '0;
          state_nxt  = S_DIV;
        end else begin
          sum_nxt   = sum_add;
          count_nxt = count_inc;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt  = div_ge ? COUNT_W'(div_trial - {1'b0, divisor}) : div_trial[COUNT_W-1:0];
        quo_nxt  = {quo_r[RAD_W-2:0], div_ge};
        num_nxt  = num_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        srem_nxt = sq_ge ? SREM_W'(sq_trial - sq_sub) : sq_trial[SREM_W-1:0];
        root_nxt = {root_r[RMS_W-2:0], sq_ge};
        quo_nxt  = quo_r << 2;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == SQRT_LAST) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // Wait for the output register to drain, then publish.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rms_nxt   = root_r;
          out_count_nxt = wcount_r;
          out_final_nxt = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      hop_r       <= HOP_RESET;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      hop_r       <= hop_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    sq_r        <= sq_nxt;
    last_r      <= last_nxt;
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    wcount_r    <= wcount_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    out_rms_r   <= out_rms_nxt;
    out_count_r <= out_count_nxt;
    out_final_r <= out_final_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/wre_checker.sv
// Port-level checker for windowed_rms_energy_core, bound to the top level.
// Depends on wre_pkg and windowed_rms_energy_core_defines.svh.
`default_nettype none

`include "windowed_rms_energy_core_defines.svh"

module wre_checker
  import wre_pkg::*;
(
  input wire                        clk,
  input wire                        rst_n,
  input wire                        cfg_wr_en,
  input wire [HOP_W-1:0]            cfg_wr_data,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire signed [SAMPLE_W-1:0]  in_sample,
  input wire                        in_end_of_stream,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire [RMS_W-1:0]            out_rms_value,
  input wire [COUNT_W-1:0]          out_window_count,
  input wire                        out_final_window
);

  // A sample is still being squared after it is accepted, so an accepted sample always blocks the next.
  `WRE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "sample taken while previous one still in work")

  // Hold a stalled result.
  `WRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rms_value) && $stable(out_window_count) && $stable(out_final_window), "stalled result changed")

  // Every window holds at least one sample.
  `WRE_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid, out_window_count != '0, "result with empty window")

  // Full scale is 1.0.
  `WRE_ASSERT_NOW(a_rms_range, clk, rst_n, out_valid, out_rms_value <= RMS_MAX, "rms above full scale")

endmodule

bind windowed_rms_energy_core wre_checker u_wre_checker (.*);

`default_nettype wire
